/* src/pattern_match_one_mismatch_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for pattern_match_one_mismatch
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PATTERN_MATCH_ONE_MISMATCH_ASSERT_SVH
`define PATTERN_MATCH_ONE_MISMATCH_ASSERT_SVH

`ifndef SYNTHESIS
`define PMOM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PMOM_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PMOM_ASSERT(label, clk, rst, prop, msg)
`define PMOM_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

/* src/pmom_pkg.sv */
// ----------------------------------------------------------------------------
// pmom_pkg
// Shared codes, defaults and types of the one-mismatch pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package pmom_pkg;

   localparam int MAX_PAT_DEFAULT  = 64;
   localparam int MAX_TEXT_DEFAULT = 65536;

   localparam logic [1:0] REQ_PATTERN = 2'd0;
   localparam logic [1:0] REQ_TEXT    = 2'd1;
   localparam logic [1:0] REQ_FINISH  = 2'd2;

   localparam logic KIND_POSITION = 1'b0;
   localparam logic KIND_COUNT    = 1'b1;

   localparam logic [1:0] ACC_SAT = 2'd2;

   typedef struct packed {
      logic load;
      logic step;
      logic clear;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* src/pmom_cell.sv */
// ----------------------------------------------------------------------------
// pmom_cell
// One comparator cell: holds a pattern byte and the mismatch count of the
// candidate window passing through it.
// ----------------------------------------------------------------------------
`default_nettype none

module pmom_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pmom_pkg::cell_ctrl_type ctrl,
   input  wire logic [7:0]            text_char,
   input  wire logic [7:0]            pat_prev,
   input  wire logic                  used_prev,
   input  wire logic [1:0]            acc_from_next,
   output logic      [7:0]            pat_q,
   output logic                       used_q,
   output logic      [1:0]            acc_q,
   output logic      [1:0]            acc_sum
);
   import pmom_pkg::*;

   logic [7:0] pat_ff;
   logic       used_ff;
   logic [1:0] acc_ff;
   logic       mismatch;

   assign mismatch = (text_char != pat_ff);
   assign acc_sum  = (acc_from_next == ACC_SAT) ? ACC_SAT
                                                : acc_from_next + {1'b0, mismatch};

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         pat_ff <= pat_prev;
      end
      if (ctrl.step) begin
         acc_ff <= acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         used_ff <= 1'b0;
      end else if (ctrl.load) begin
         used_ff <= used_prev;
      end
   end

   assign pat_q  = pat_ff;
   assign used_q = used_ff;
   assign acc_q  = used_ff ? acc_ff : 2'd0;

endmodule

`default_nettype wire

/* src/pmom_out_buf.sv */
// ----------------------------------------------------------------------------
// pmom_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module pmom_out_buf #(
   parameter int DATA_W = 18
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   output logic                   out_valid,
   output logic      [DATA_W-1:0] out_data,
   input  wire logic              out_stall
);

   logic              head_valid_ff, head_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [DATA_W-1:0] head_ff, head_in;
   logic [DATA_W-1:0] skid_ff, skid_in;
   logic              pop;

   assign pop = head_valid_ff && !out_stall;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop || !head_valid_ff) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_in       = push_data;
            skid_valid_in = push;
         end else begin
            head_in       = push_data;
            head_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

endmodule

`default_nettype wire

/* src/pattern_match_one_mismatch.sv */
// Each result item is registered into the output buffer's head or skid entry.
// Throughput: one item per cycle while req_stall is low; every cell of the
// comparator row updates in the same cycle a text byte is taken.
// A two-entry output buffer holds results; req_stall rises only when it is full.
// Reset clears counters, match total and the cells' in-use flags at once.
// ----------------------------------------------------------------------------
// pattern_match_one_mismatch
// Streams text through a row of comparator cells and reports every window
// that differs from the pattern in at most one byte, and each query's total.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pattern_match_one_mismatch_assert.svh"

module pattern_match_one_mismatch #(
   parameter int MAX_PAT  = pmom_pkg::MAX_PAT_DEFAULT,
   parameter int MAX_TEXT = pmom_pkg::MAX_TEXT_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_type,
   input  wire logic [7:0]                     req_char_in,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_result_kind,
   output logic      [$clog2(MAX_TEXT+1)-1:0]  rsp_result_value
);
   import pmom_pkg::*;

   localparam int LEN_W  = $clog2(MAX_PAT + 1);
   localparam int SEEN_W = $clog2(MAX_TEXT + 1);
   localparam int CMP_W  = (SEEN_W > LEN_W) ? SEEN_W : LEN_W;
   localparam int DATA_W = SEEN_W + 1;

   logic              accept;
   logic              is_pattern, is_text, is_finish;
   logic              text_started;
   cell_ctrl_type     ctrl;

   logic [LEN_W-1:0]  pat_len_ff, pat_len_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [SEEN_W-1:0] total_ff, total_in;
   logic              over_ff, over_in;

   logic [7:0]        pat_q   [MAX_PAT];
   logic              used_q  [MAX_PAT];
   logic [1:0]        acc_q   [MAX_PAT];
   logic [1:0]        acc_head;

   logic              window_full;
   logic              hit;
   logic [CMP_W-1:0]  pos_wide;
   logic [SEEN_W-1:0] pos;
   logic              push;
   logic [DATA_W-1:0] push_data;
   logic [DATA_W-1:0] out_data;

   assign accept     = req_valid && !req_stall;
   assign is_pattern = accept && (req_type == REQ_PATTERN);
   assign is_text    = accept && (req_type == REQ_TEXT);
   assign is_finish  = accept && (req_type == REQ_FINISH);

   assign text_started = (seen_ff != '0) || over_ff;

   assign ctrl.load  = is_pattern && !text_started && (pat_len_ff < LEN_W'(MAX_PAT));
   assign ctrl.step  = is_text;
   assign ctrl.clear = is_finish;

   genvar k;
   generate
      for (k = 0; k < MAX_PAT; k++) begin : g_cell
         logic [7:0] pat_prev;
         logic       used_prev;
         logic [1:0] acc_from_next;
         logic [1:0] acc_sum;

         if (k == 0) begin : g_first
            assign pat_prev  = req_char_in;
            assign used_prev = 1'b1;
            assign acc_head  = acc_sum;
         end else begin : g_rest
            assign pat_prev  = pat_q[k-1];
            assign used_prev = used_q[k-1];
         end

         if (k == MAX_PAT - 1) begin : g_last
            assign acc_from_next = 2'd0;
         end else begin : g_inner
            assign acc_from_next = acc_q[k+1];
         end

         pmom_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctrl          (ctrl),
            .text_char     (req_char_in),
            .pat_prev      (pat_prev),
            .used_prev     (used_prev),
            .acc_from_next (acc_from_next),
            .pat_q         (pat_q[k]),
            .used_q        (used_q[k]),
            .acc_q         (acc_q[k]),
            .acc_sum       (acc_sum)
         );
      end
   endgenerate

   always_comb begin
      seen_in = seen_ff;
      over_in = over_ff;
      if (is_text) begin
         if (seen_ff == SEEN_W'(MAX_TEXT)) begin
            over_in = 1'b1;
         end else begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   assign window_full = over_in || (CMP_W'(seen_in) >= CMP_W'(pat_len_ff));
   assign hit = is_text && (pat_len_ff != '0) && window_full && (acc_head < ACC_SAT);

   assign pos_wide = CMP_W'(seen_in) - CMP_W'(pat_len_ff) + 1'b1;
   assign pos      = over_in ? SEEN_W'(MAX_TEXT) : pos_wide[SEEN_W-1:0];

   always_comb begin
      pat_len_in = pat_len_ff;
      total_in   = total_ff;
      if (ctrl.load) begin
         pat_len_in = pat_len_ff + 1'b1;
      end
      if (hit && (total_ff != SEEN_W'(MAX_TEXT))) begin
         total_in = total_ff + 1'b1;
      end
      if (is_finish) begin
         pat_len_in = '0;
         total_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || is_finish) begin
         seen_ff <= '0;
         over_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         over_ff <= over_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff <= '0;
         total_ff   <= '0;
      end else begin
         pat_len_ff <= pat_len_in;
         total_ff   <= total_in;
      end
   end

   assign push      = hit || is_finish;
   assign push_data = is_finish ? {KIND_COUNT, total_ff} : {KIND_POSITION, pos};

   pmom_out_buf #(
      .DATA_W (DATA_W)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_stall (rsp_stall)
   );

   assign rsp_result_kind  = out_data[DATA_W-1];
   assign rsp_result_value = out_data[SEEN_W-1:0];

   `PMOM_ASSERT(a_finish_gives_item, clock, reset, is_finish |=> rsp_valid, "finish produced no item")
   `PMOM_ASSERT(a_stall_only_when_held, clock, reset, req_stall |-> rsp_valid, "stall without pending item")
   `PMOM_ASSERT_NEVER(a_pat_len_range, clock, reset, pat_len_ff > LEN_W'(MAX_PAT), "pattern length overrun")
   `PMOM_ASSERT_NEVER(a_seen_range, clock, reset, seen_ff > SEEN_W'(MAX_TEXT), "text count overrun")
   `PMOM_ASSERT(a_finish_clears, clock, reset, is_finish |=> (pat_len_ff == '0 && total_ff == '0), "finish did not clear query")

endmodule

`default_nettype wire

/* tb/pattern_match_one_mismatch_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_match_one_mismatch_check
// Watches both channels of the one-mismatch pattern matcher, predicts each
// match position and query total from the items taken, and compares every
// result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pattern_match_one_mismatch_check #(
   parameter int MAX_PAT  = pmom_pkg::MAX_PAT_DEFAULT,
   parameter int MAX_TEXT = pmom_pkg::MAX_TEXT_DEFAULT,
   parameter int VALUE_W  = $clog2(MAX_TEXT + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_char_in,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_result_kind,
   input  logic [VALUE_W-1:0] rsp_result_value,
   output int                 fail_count,
   output int                 pending,
   output int                 results_seen
);
   import pmom_pkg::*;

   typedef struct packed {
      logic               kind;
      logic [VALUE_W-1:0] value;
   } match_result_type;

   match_result_type expected_results[$];

   logic [7:0]  pattern_bytes[MAX_PAT];
   logic [7:0]  text_ring[MAX_PAT];
   int unsigned pattern_len;
   int unsigned text_count;
   int unsigned hit_total;
   int unsigned ring_ptr;
   bit          text_overflowed;
   int          fails = 0;
   int          seen  = 0;

   function automatic bit window_hits();
      int unsigned diffs;
      int unsigned j;
      int unsigned idx;
      diffs = 0;
      for (j = 0; j < pattern_len; j++) begin
         idx = (ring_ptr + MAX_PAT - pattern_len + j) % MAX_PAT;
         if (text_ring[idx] != pattern_bytes[j])
            diffs++;
      end
      return diffs <= 1;
   endfunction

   task automatic clear_query();
      pattern_len     = 0;
      text_count      = 0;
      hit_total       = 0;
      ring_ptr        = 0;
      text_overflowed = 1'b0;
   endtask

   task automatic predict_item(input logic [1:0] kind, input logic [7:0] ch);
      match_result_type r;
      case (kind)
         REQ_PATTERN: begin
            if (text_count == 0 && !text_overflowed && pattern_len < MAX_PAT) begin
               pattern_bytes[pattern_len] = ch;
               pattern_len++;
            end
         end
         REQ_TEXT: begin
            text_ring[ring_ptr] = ch;
            ring_ptr = (ring_ptr + 1) % MAX_PAT;
            if (text_count >= MAX_TEXT)
               text_overflowed = 1'b1;
            else
               text_count++;
            if (pattern_len != 0 && (text_overflowed || text_count >= pattern_len)
                && window_hits()) begin
               if (hit_total < MAX_TEXT)
                  hit_total++;
               r.kind  = KIND_POSITION;
               r.value = text_overflowed ? VALUE_W'(MAX_TEXT)
                                         : VALUE_W'(text_count - pattern_len + 1);
               expected_results.insert(expected_results.size(), r);
            end
         end
         REQ_FINISH: begin
            r.kind  = KIND_COUNT;
            r.value = VALUE_W'(hit_total);
            expected_results.insert(expected_results.size(), r);
            clear_query();
         end
         default: begin
         end
      endcase
   endtask

   task automatic compare_result();
      match_result_type want;
      seen++;
      if (expected_results.size() == 0) begin
         $error("unexpected result: result_kind %0d, result_value %0d",
                rsp_result_kind, rsp_result_value);
         fails++;
      end else begin
         want = expected_results.pop_front();
         if (rsp_result_kind !== want.kind) begin
            $error("result_kind: expected %0d, actual %0d", want.kind, rsp_result_kind);
            fails++;
         end
         if (rsp_result_value !== want.value) begin
            $error("result_value: expected %0d, actual %0d", want.value,
                   rsp_result_value);
            fails++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PAT; i++) begin
            pattern_bytes[i] = 8'h00;
            text_ring[i]     = 8'h00;
         end
         clear_query();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            compare_result();
         if (req_valid && !req_stall)
            predict_item(req_type, req_char_in);
      end
      fail_count   <= fails;
      pending      <= expected_results.size();
      results_seen <= seen;
   end

endmodule

/* tb/pattern_match_one_mismatch_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_match_one_mismatch_test
// Drives pattern, text, finish and unused items into the matcher with random
// gaps and result stalls: directed corner cases and random queries built
// around planted near-copies of the pattern. The checker judges every result
// item.
// ----------------------------------------------------------------------------
module pattern_match_one_mismatch_test;
   import pmom_pkg::*;

   localparam int MAX_PAT      = MAX_PAT_DEFAULT;
   localparam int MAX_TEXT     = MAX_TEXT_DEFAULT;
   localparam int VALUE_W      = $clog2(MAX_TEXT + 1);
   localparam int RANDOM_ITEMS = 750;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 5;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type    = REQ_PATTERN;
   logic [7:0]         req_char_in = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic               rsp_result_kind;
   logic [VALUE_W-1:0] rsp_result_value;

   int fail_count;
   int pending;
   int results_seen;
   int idle_cycles = 0;
   int stall_left  = 0;
   int stall_roll;
   int item_total  = 0;
   int query_total = 0;
   bit quiet       = 1'b0;

   always #5 clock = ~clock;

   pattern_match_one_mismatch uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_value (rsp_result_value)
   );

   pattern_match_one_mismatch_check #(
      .MAX_PAT  (MAX_PAT),
      .MAX_TEXT (MAX_TEXT),
      .VALUE_W  (VALUE_W)
   ) checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_value (rsp_result_value),
      .fail_count       (fail_count),
      .pending          (pending),
      .results_seen     (results_seen)
   );

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         stall_roll = $urandom_range(99, 0);
         if (stall_roll < 12) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(2, 0);
         end else if (stall_roll < 14) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(40, 8);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99, 0);
      if (quiet || roll < 55)
         return 0;
      if (roll < 88)
         return $urandom_range(3, 1);
      if (roll < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [7:0] ch);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_char_in <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic run_query(input bit force_full);
      int          plen;
      int          used_len;
      int          tlen;
      int          alph;
      int          sent;
      int          flip_a;
      int          flip_b;
      int          roll;
      logic [7:0]  base;
      logic [7:0]  ch;
      logic [7:0]  pat[MAX_PAT];
      quiet = ($urandom_range(7, 0) == 0);
      roll  = $urandom_range(3, 0);
      alph  = (roll == 0) ? 2 : (roll == 1) ? 3 : (roll == 2) ? 4 : 256;
      base  = 8'($urandom);
      roll  = $urandom_range(19, 0);
      if (force_full)
         plen = MAX_PAT + 2;
      else if (roll == 0)
         plen = 0;
      else if (roll < 3)
         plen = $urandom_range(MAX_PAT + 6, MAX_PAT - 4);
      else
         plen = $urandom_range(8, 1);
      used_len = (plen > MAX_PAT) ? MAX_PAT : plen;

      // broken start: text first, so the pattern bytes that follow are dropped
      if ($urandom_range(15, 0) == 0) begin
         send_item(REQ_TEXT, base + 8'($urandom_range(alph - 1, 0)));
         item_total++;
      end
      for (int i = 0; i < plen; i++) begin
         ch = base + 8'($urandom_range(alph - 1, 0));
         if (i < MAX_PAT)
            pat[i] = ch;
         send_item(REQ_PATTERN, ch);
         item_total++;
      end

      tlen = (plen > 8) ? plen + $urandom_range(80, 0) : $urandom_range(40, 0);
      sent = 0;
      while (sent < tlen) begin
         if ($urandom_range(29, 0) == 0)
            send_item($urandom_range(1, 0) ? REQ_UNUSED : REQ_PATTERN, 8'($urandom));
         if (used_len > 0 && $urandom_range(2, 0) == 0) begin
            // plant a copy with zero, one or two bytes changed
            roll   = $urandom_range(5, 0);
            flip_a = (roll < 2) ? -1 : $urandom_range(used_len - 1, 0);
            flip_b = (roll == 5) ? $urandom_range(used_len - 1, 0) : -1;
            for (int j = 0; j < used_len; j++) begin
               ch = pat[j];
               if (j == flip_a || j == flip_b)
                  ch = ch ^ 8'($urandom_range(255, 1));
               send_item(REQ_TEXT, ch);
               item_total++;
               sent++;
            end
         end else begin
            send_item(REQ_TEXT, base + 8'($urandom_range(alph - 1, 0)));
            item_total++;
            sent++;
         end
      end
      send_item(REQ_FINISH, 8'($urandom));
      item_total++;
      query_total++;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty pattern: text is counted but never matches
      send_item(REQ_TEXT, 8'h00);
      send_item(REQ_TEXT, 8'hFF);
      send_item(REQ_FINISH, 8'h5A);
      // exact hit, two-byte miss, one-byte hit, late pattern byte, unused code
      send_item(REQ_PATTERN, 8'h00);
      send_item(REQ_PATTERN, 8'hFF);
      send_item(REQ_TEXT, 8'h00);
      send_item(REQ_TEXT, 8'hFF);
      send_item(REQ_TEXT, 8'h01);
      send_item(REQ_TEXT, 8'hFF);
      send_item(REQ_PATTERN, 8'hAA);
      send_item(REQ_UNUSED, 8'hFF);
      send_item(REQ_TEXT, 8'h23);
      send_item(REQ_FINISH, 8'h00);
      // text ahead of the pattern
      send_item(REQ_TEXT, 8'h80);
      send_item(REQ_PATTERN, 8'h80);
      send_item(REQ_TEXT, 8'h80);
      send_item(REQ_FINISH, 8'hFF);
      // pattern with no text
      send_item(REQ_PATTERN, 8'h7F);
      send_item(REQ_FINISH, 8'h01);
      drain_results();

      run_query(1'b1);
      while (item_total < RANDOM_ITEMS) begin
         run_query(1'b0);
         if ($urandom_range(4, 0) == 0)
            drain_results();
      end
      drain_results();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Summary: %0d items over %0d random queries plus directed cases, %0d results",
               item_total, query_total, results_seen);
      $display("Summary: empty, full-length and dropped pattern bytes, unused codes, stalls");
      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
